// ----- hdl/erfp_pkg.sv -----
// Shared types, codes and the CRC-8 step for the enclosure reply frame parser.
package erfp_pkg;

	localparam logic [7:0] MARKER_BYTE = 8'h2A;
	localparam logic [7:0] TYPE_DOME   = 8'hB3;
	localparam logic [7:0] TYPE_DEHUM  = 8'hB8;
	localparam logic [7:0] TYPE_ROOF   = 8'hB4;

	localparam logic [2:0] LEN_DOME  = 3'd2;
	localparam logic [2:0] LEN_DEHUM = 3'd1;
	localparam logic [2:0] LEN_ROOF  = 3'd6;
	localparam logic [2:0] LEN_NONE  = 3'd0;

	localparam int PAYLOAD_DEPTH = 6;

	// Frame byte positions
	localparam logic [3:0] POS_HUNT  = 4'd0;
	localparam logic [3:0] POS_TYPE  = 4'd1;
	localparam logic [3:0] POS_ERROR = 4'd2;
	localparam logic [3:0] POS_DATA  = 4'd3;

	localparam logic [1:0] MOTION_OPENING = 2'd1;
	localparam logic [1:0] MOTION_CLOSING = 2'd2;
	localparam logic [7:0] PHASE_MOVING   = 8'd1;
	localparam logic [7:0] PHASE_OPEN     = 8'd2;
	localparam logic [7:0] PHASE_CLOSED   = 8'd3;

	localparam logic [0:0] CFG_POLY  = 1'b0;
	localparam logic [0:0] CFG_START = 1'b1;

	typedef enum logic [2:0] {
		KIND_DOME   = 3'd0,
		KIND_DEHUM  = 3'd1,
		KIND_ROOF   = 3'd2,
		KIND_REJECT = 3'd3,
		KIND_OTHER  = 3'd4
	} frame_kind_t;

	typedef enum logic [2:0] {
		OVR_CLOSED  = 3'd0,
		OVR_OPENING = 3'd1,
		OVR_CLOSING = 3'd2,
		OVR_OPEN    = 3'd3,
		OVR_UNKNOWN = 3'd4
	} overall_state_t;

	// MSB-first CRC-8 over one byte, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- hdl/erfp_in_if.sv -----
// Input byte channel of the frame parser.
interface erfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/erfp_out_if.sv -----
// Result channel of the frame parser.
interface erfp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] frame_kind;
	logic [2:0] overall_state;
	logic [7:0] dome_code;
	logic [7:0] dome_outcome;
	logic       dehum_channels_on;
	logic       dehum_enclosure_on;
	logic       vent_on;
	logic [7:0] sidewall_word;
	logic [7:0] handrail_word;
	logic [7:0] roof_flags;
	logic [7:0] roof_phase;
	logic       remote_mode;

	modport source (output valid, output frame_kind, output overall_state, output dome_code,
		output dome_outcome, output dehum_channels_on, output dehum_enclosure_on,
		output vent_on, output sidewall_word, output handrail_word, output roof_flags,
		output roof_phase, output remote_mode, input ready);
	modport sink (input valid, input frame_kind, input overall_state, input dome_code,
		input dome_outcome, input dehum_channels_on, input dehum_enclosure_on,
		input vent_on, input sidewall_word, input handrail_word, input roof_flags,
		input roof_phase, input remote_mode, output ready);
endinterface

// ----- hdl/enclosure_reply_frame_parser.sv -----
// Enclosure reply frame parser top level.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------
//   in_ch    | in  | rx_byte, one reply byte per item
//   out_ch   | out | frame_kind plus all kept status fields
//   cfg      | in  | cfg_we / cfg_index / cfg_wdata (poly, start)
//
// One byte per cycle when not stalled: input register, then the CRC and frame logic
// into the state and result registers. A result is registered once its closing byte leaves the input register.
// Bytes that end no frame keep flowing while a result waits; a frame-ending
// byte waits in the input register until the result register is free.
// Reset clears all control and kept status; poly resets to 0x07, start to 0x00.
module enclosure_reply_frame_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	erfp_in_if.sink    in_ch,
	erfp_out_if.source out_ch
);

	logic [7:0] poly_q;
	logic [7:0] start_q;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [3:0] pos_q;
	logic [7:0] type_q;
	logic [7:0] err_q;
	logic [7:0] crc_q;
	logic [7:0] payload_q [erfp_pkg::PAYLOAD_DEPTH];

	logic [7:0] dome_code_q;
	logic [7:0] dome_outcome_q;
	logic [2:0] dehum_q;
	logic [7:0] sidewall_q;
	logic [7:0] handrail_q;
	logic [7:0] roof_flags_q;
	logic [7:0] roof_phase_q;
	erfp_pkg::overall_state_t overall_q;

	logic                  out_valid_q;
	erfp_pkg::frame_kind_t kind_q;

	// next-state logic
	logic [3:0] pos_d;
	logic [7:0] type_d;
	logic [7:0] err_d;
	logic [7:0] crc_d;
	logic [7:0] crc_new;
	logic [2:0] idx;
	logic [2:0] plen;
	logic       wr_en;
	logic       has_res;
	erfp_pkg::frame_kind_t kind_d;
	logic       upd_dome;
	logic       upd_dehum;
	logic       upd_roof;
	erfp_pkg::overall_state_t overall_d;
	logic [1:0] motion;
	logic       out_free;
	logic       go;

	assign out_free = !out_valid_q || out_ch.ready;
	assign go = valid_s1 && (!has_res || out_free);
	assign in_ch.ready = !valid_s1 || go;

	assign crc_new = erfp_pkg::crc8_update((pos_q == erfp_pkg::POS_HUNT) ? start_q : crc_q,
		byte_s1, poly_q);
	assign idx = pos_q[2:0] - erfp_pkg::POS_DATA[2:0];

	always_comb begin
		case (type_q)
			erfp_pkg::TYPE_DOME:  plen = erfp_pkg::LEN_DOME;
			erfp_pkg::TYPE_DEHUM: plen = erfp_pkg::LEN_DEHUM;
			erfp_pkg::TYPE_ROOF:  plen = erfp_pkg::LEN_ROOF;
			default:              plen = erfp_pkg::LEN_NONE;
		endcase
	end

	always_comb begin
		pos_d = pos_q;
		type_d = type_q;
		err_d = err_q;
		crc_d = crc_q;
		wr_en = 1'b0;
		has_res = 1'b0;
		kind_d = erfp_pkg::KIND_OTHER;
		upd_dome = 1'b0;
		upd_dehum = 1'b0;
		upd_roof = 1'b0;
		case (pos_q)
			erfp_pkg::POS_HUNT: begin
				if (byte_s1 == erfp_pkg::MARKER_BYTE) begin
					pos_d = erfp_pkg::POS_TYPE;
					crc_d = crc_new;
				end
			end
			erfp_pkg::POS_TYPE: begin
				type_d = byte_s1;
				crc_d = crc_new;
				pos_d = erfp_pkg::POS_ERROR;
			end
			erfp_pkg::POS_ERROR: begin
				err_d = byte_s1;
				crc_d = crc_new;
				pos_d = erfp_pkg::POS_DATA;
			end
			default: begin
				if (plen == erfp_pkg::LEN_NONE) begin
					pos_d = erfp_pkg::POS_HUNT;
					has_res = 1'b1;
					kind_d = erfp_pkg::KIND_OTHER;
				end else if (idx < plen) begin
					wr_en = 1'b1;
					crc_d = crc_new;
					pos_d = pos_q + 4'd1;
				end else begin
					// CRC byte closes the frame
					pos_d = erfp_pkg::POS_HUNT;
					has_res = 1'b1;
					if (byte_s1 != crc_q || err_q != 8'd0) begin
						kind_d = erfp_pkg::KIND_REJECT;
					end else if (type_q == erfp_pkg::TYPE_DOME) begin
						kind_d = erfp_pkg::KIND_DOME;
						upd_dome = 1'b1;
					end else if (type_q == erfp_pkg::TYPE_DEHUM) begin
						kind_d = erfp_pkg::KIND_DEHUM;
						upd_dehum = 1'b1;
					end else begin
						kind_d = erfp_pkg::KIND_ROOF;
						upd_roof = 1'b1;
					end
				end
			end
		endcase
	end

	// overall state from the new roof bytes and the dome code held before
	assign motion = payload_q[1][2:1];
	always_comb begin
		if ((payload_q[2] == erfp_pkg::PHASE_MOVING && motion == erfp_pkg::MOTION_OPENING) ||
			(dome_code_q inside {8'd2, 8'd4, 8'd7, 8'd8, 8'd11, 8'd13})) begin
			overall_d = erfp_pkg::OVR_OPENING;
		end else if ((payload_q[2] == erfp_pkg::PHASE_MOVING &&
			motion == erfp_pkg::MOTION_CLOSING) ||
			(dome_code_q inside {8'd3, 8'd5, 8'd6, 8'd9, 8'd10, 8'd12, 8'd14})) begin
			overall_d = erfp_pkg::OVR_CLOSING;
		end else if (payload_q[2] == erfp_pkg::PHASE_OPEN) begin
			overall_d = erfp_pkg::OVR_OPEN;
		end else if (payload_q[2] == erfp_pkg::PHASE_CLOSED) begin
			overall_d = erfp_pkg::OVR_CLOSED;
		end else begin
			overall_d = erfp_pkg::OVR_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= 8'h07;
			start_q <= 8'h00;
		end else if (cfg_we) begin
			case (cfg_index)
				erfp_pkg::CFG_POLY:  poly_q <= cfg_wdata;
				erfp_pkg::CFG_START: start_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= erfp_pkg::POS_HUNT;
			type_q <= 8'd0;
			err_q <= 8'd0;
			crc_q <= 8'd0;
			dome_code_q <= 8'd0;
			dome_outcome_q <= 8'd0;
			dehum_q <= 3'd0;
			sidewall_q <= 8'd0;
			handrail_q <= 8'd0;
			roof_flags_q <= 8'd0;
			roof_phase_q <= 8'd0;
			overall_q <= erfp_pkg::OVR_CLOSED;
		end else if (go) begin
			pos_q <= pos_d;
			type_q <= type_d;
			err_q <= err_d;
			crc_q <= crc_d;
			if (upd_dome) begin
				dome_code_q <= payload_q[0];
				dome_outcome_q <= payload_q[1];
			end
			if (upd_dehum) begin
				dehum_q <= payload_q[0][2:0];
			end
			if (upd_roof) begin
				roof_flags_q <= payload_q[1];
				roof_phase_q <= payload_q[2];
				sidewall_q <= payload_q[4];
				handrail_q <= payload_q[5];
				overall_q <= overall_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && wr_en) begin
			payload_q[idx] <= byte_s1;
		end
	end

	// kept status only changes together with a new result, so it drives the result directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q <= erfp_pkg::KIND_DOME;
		end else begin
			if (out_free) begin
				out_valid_q <= go && has_res;
			end
			if (go && has_res) begin
				kind_q <= kind_d;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.frame_kind = kind_q;
	assign out_ch.overall_state = overall_q;
	assign out_ch.dome_code = dome_code_q;
	assign out_ch.dome_outcome = dome_outcome_q;
	assign out_ch.dehum_channels_on = dehum_q[0];
	assign out_ch.dehum_enclosure_on = dehum_q[1];
	assign out_ch.vent_on = dehum_q[2];
	assign out_ch.sidewall_word = sidewall_q;
	assign out_ch.handrail_word = handrail_q;
	assign out_ch.roof_flags = roof_flags_q;
	assign out_ch.roof_phase = roof_phase_q;
	assign out_ch.remote_mode = roof_flags_q[0];

endmodule
